// ===== rtl/mf3_pkg.sv =====
// Shared constants, register codes and types of the 3x3 median filter.
`default_nettype none

package mf3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int WIN_SIDE       = 3;
    localparam int WIN_TAPS       = 9;
    localparam int HEIGHT_LIMIT   = 4096;

    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 1024;

    // Result queue depth; it also bounds the number of results in flight.
    localparam int FIFO_DEPTH = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [COL_W-1:0] centre_col;
        logic [ROW_W-1:0] centre_row;
        logic             frame_end;
    } t_tag;

endpackage

`default_nettype wire

// ===== rtl/mf3_pix_if.sv =====
// Pixel request channel: valid, ready and one pixel.
`default_nettype none

interface mf3_pix_if #(
    parameter int PIX_W = mf3_pkg::PIXEL_BITS_DEF
);
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/mf3_res_if.sv =====
// Result request channel: valid, ready, median and centre coordinates.
`default_nettype none

interface mf3_res_if #(
    parameter int PIX_W = mf3_pkg::PIXEL_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic [PIX_W-1:0]         median;
    logic [mf3_pkg::COL_W-1:0] centre_col;
    logic [mf3_pkg::ROW_W-1:0] centre_row;
    logic                     frame_end;

    modport source (output valid, output median, output centre_col, output centre_row,
                    output frame_end, input ready);
    modport sink   (input valid, input median, input centre_col, input centre_row,
                    input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/mf3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/mf3_sort_cell.sv =====
// One insertion cell of the sorting chain: adds one window value to a sorted list.
`default_nettype none

module mf3_sort_cell #(
    parameter int PIX_W = mf3_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    input  wire logic [mf3_pkg::WIN_TAPS-1:0][PIX_W-1:0] i_sorted,
    input  wire logic [mf3_pkg::WIN_TAPS-1:0][PIX_W-1:0] i_pend,
    input  wire mf3_pkg::t_tag                           i_tag,
    output logic                                         o_valid,
    output logic      [mf3_pkg::WIN_TAPS-1:0][PIX_W-1:0] o_sorted,
    output logic      [mf3_pkg::WIN_TAPS-1:0][PIX_W-1:0] o_pend,
    output mf3_pkg::t_tag                                o_tag
);

    localparam int TAPS = mf3_pkg::WIN_TAPS;

    logic [TAPS-1:0]            w_gt;
    logic [PIX_W-1:0]           w_val;
    logic [TAPS-1:0][PIX_W-1:0] n_sorted;
    logic [TAPS-1:0][PIX_W-1:0] n_pend;

    logic                       r_valid;
    logic [TAPS-1:0][PIX_W-1:0] r_sorted;
    logic [TAPS-1:0][PIX_W-1:0] r_pend;
    mf3_pkg::t_tag              r_tag;

    // The list is ascending; unused slots hold all ones, so the top slot that
    // falls off on each insertion is always a filler or an equal value.
    always_comb begin
        w_val = i_pend[0];
        for (int j = 0; j < TAPS; j++) begin
            w_gt[j] = i_sorted[j] > w_val;
        end
        n_sorted[0] = w_gt[0] ? w_val : i_sorted[0];
        for (int j = 1; j < TAPS; j++) begin
            if (!w_gt[j]) begin
                n_sorted[j] = i_sorted[j];
            end else if (!w_gt[j-1]) begin
                n_sorted[j] = w_val;
            end else begin
                n_sorted[j] = i_sorted[j-1];
            end
        end
        for (int j = 0; j < TAPS - 1; j++) begin
            n_pend[j] = i_pend[j+1];
        end
        n_pend[TAPS-1] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_sorted <= n_sorted;
        r_pend   <= n_pend;
        r_tag    <= i_tag;
    end

    assign o_valid  = r_valid;
    assign o_sorted = r_sorted;
    assign o_pend   = r_pend;
    assign o_tag    = r_tag;

endmodule

`default_nettype wire

// ===== rtl/mf3_out_fifo.sv =====
// Result queue that decouples the filter pipeline from the result sink.
`default_nettype none

module mf3_out_fifo #(
    parameter int PIX_W = mf3_pkg::PIXEL_BITS_DEF,
    parameter int DEPTH = mf3_pkg::FIFO_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [PIX_W-1:0] i_median,
    input  wire mf3_pkg::t_tag    i_tag,
    mf3_res_if.source             o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [PIX_W-1:0] r_median [DEPTH];
    mf3_pkg::t_tag    r_tag    [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             w_pop;

    assign w_pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_median[r_wr] <= i_median;
            r_tag[r_wr]    <= i_tag;
        end
    end

    assign o_out.valid      = (r_count != '0);
    assign o_out.median     = r_median[r_rd];
    assign o_out.centre_col = r_tag[r_rd].centre_col;
    assign o_out.centre_row = r_tag[r_rd].centre_row;
    assign o_out.frame_end  = r_tag[r_rd].frame_end;

endmodule

`default_nettype wire

// ===== rtl/median_filter_3x3.sv =====
// Top level of the streaming 3x3 median filter.
//
//  channel   direction  handshake            carries
//  i_in      in         i_in.valid/ready     pixel
//  o_out     out        o_out.valid/ready    median, centre_col, centre_row, frame_end
//  i_cfg_*   in         i_cfg_we             image_width (index 0), image_height (index 1)
//
// One pixel is taken per clock while input ready is high; the line buffers are read
// and rewritten once per pixel. A result passes the line buffer read, the chain of
// insertion cells and the result queue, in that order, before it leaves.
// Reset clears the counters, window and queue at once; there is no clearing pass.
// Input ready drops only once sixteen results are queued or still in the pipeline.
`default_nettype none

module median_filter_3x3 #(
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mf3_pix_if.sink                              i_in,
    mf3_res_if.source                            o_out
);

    localparam int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int TAPS  = mf3_pkg::WIN_TAPS;
    localparam int SIDE  = mf3_pkg::WIN_SIDE;
    localparam int COLW  = mf3_pkg::COL_W;
    localparam int ROWW  = mf3_pkg::ROW_W;
    localparam int WIDW  = mf3_pkg::CFG_WID_W;
    localparam int HGTW  = mf3_pkg::CFG_HGT_W;
    localparam int DEPTH = mf3_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH + 1);

    // Configuration
    logic [WIDW-1:0] r_cfg_width;
    logic [HGTW-1:0] r_cfg_height;
    logic [WIDW-1:0] w_width;
    logic [HGTW-1:0] w_height;

    // Position of the next pixel
    logic [COLW-1:0] r_col;
    logic [ROWW-1:0] r_row;
    logic            w_line_end;
    logic            w_frame_last;
    logic            w_emit;
    logic [AW-1:0]   w_idx;
    logic            w_in_acc;

    // Line buffer read stage
    logic                  r_s1_valid;
    logic                  r_s1_emit;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic [AW-1:0]         r_s1_idx;
    mf3_pkg::t_tag         r_s1_tag;
    logic [PIXEL_BITS-1:0] w_prev_rd;
    logic [PIXEL_BITS-1:0] w_prev2_rd;

    // Window
    logic [TAPS-1:0][PIXEL_BITS-1:0] r_win;
    logic [TAPS-1:0][PIXEL_BITS-1:0] n_win;

    // Sorting chain
    logic                            c_valid  [TAPS+1];
    logic [TAPS-1:0][PIXEL_BITS-1:0] c_sorted [TAPS+1];
    logic [TAPS-1:0][PIXEL_BITS-1:0] c_pend   [TAPS+1];
    mf3_pkg::t_tag                   c_tag    [TAPS+1];

    // Results queued or in flight
    logic [PW-1:0] r_pend;
    logic          w_out_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDW'(mf3_pkg::RESET_WIDTH);
            r_cfg_height <= HGTW'(mf3_pkg::RESET_HEIGHT);
        end else if (i_cfg_we) begin
            case (mf3_pkg::t_cfg_reg'(i_cfg_index))
                mf3_pkg::CFG_IMAGE_WIDTH: begin
                    r_cfg_width <= i_cfg_data[WIDW-1:0];
                end
                mf3_pkg::CFG_IMAGE_HEIGHT: begin
                    r_cfg_height <= i_cfg_data[HGTW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_cfg_width < WIDW'(SIDE)) begin
            w_width = WIDW'(SIDE);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_width = WIDW'(MAX_WIDTH);
        end else begin
            w_width = r_cfg_width;
        end
        if (r_cfg_height < HGTW'(SIDE)) begin
            w_height = HGTW'(SIDE);
        end else if (32'(r_cfg_height) > mf3_pkg::HEIGHT_LIMIT) begin
            w_height = HGTW'(mf3_pkg::HEIGHT_LIMIT);
        end else begin
            w_height = r_cfg_height;
        end
    end

    assign w_line_end   = (WIDW'(r_col) + 1'b1) >= w_width;
    assign w_frame_last = w_line_end && ((HGTW'(r_row) + 1'b1) >= w_height);
    assign w_emit       = (r_col >= COLW'(2)) && (r_row >= ROWW'(2));
    assign w_idx        = (32'(r_col) < MAX_WIDTH) ? AW'(r_col) : AW'(MAX_WIDTH - 1);
    assign w_in_acc     = i_in.valid && i_in.ready;
    assign w_out_acc    = o_out.valid && o_out.ready;
    assign i_in.ready   = r_pend < PW'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_acc;
            if (w_in_acc) begin
                if (w_line_end) begin
                    r_col <= '0;
                    r_row <= w_frame_last ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
        if (w_in_acc) begin
            r_s1_emit           <= w_emit;
            r_s1_px             <= i_in.pixel;
            r_s1_idx            <= w_idx;
            r_s1_tag.centre_col <= r_col - 1'b1;
            r_s1_tag.centre_row <= r_row - 1'b1;
            r_s1_tag.frame_end  <= w_frame_last;
        end
    end

    // The previous line moves into the older buffer as the new pixel replaces it.
    // Two pixels in a row never share a column, so read and write never collide.
    mf3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_prev (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_idx),
        .i_wdata (r_s1_px),
        .i_re    (w_in_acc),
        .i_raddr (w_idx),
        .o_rdata (w_prev_rd)
    );

    mf3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_prev2 (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_idx),
        .i_wdata (w_prev_rd),
        .i_re    (w_in_acc),
        .i_raddr (w_idx),
        .o_rdata (w_prev2_rd)
    );

    always_comb begin
        n_win = r_win;
        if (r_s1_valid) begin
            for (int r = 0; r < SIDE; r++) begin
                n_win[r*SIDE]     = r_win[r*SIDE + 1];
                n_win[r*SIDE + 1] = r_win[r*SIDE + 2];
            end
            n_win[SIDE - 1]        = w_prev2_rd;
            n_win[2*SIDE - 1]      = w_prev_rd;
            n_win[SIDE*SIDE - 1]   = r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else begin
            r_win <= n_win;
        end
    end

    assign c_valid[0]  = r_s1_valid && r_s1_emit;
    assign c_sorted[0] = '1;
    assign c_pend[0]   = n_win;
    assign c_tag[0]    = r_s1_tag;

    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        mf3_sort_cell #(
            .PIX_W (PIXEL_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (c_valid[g]),
            .i_sorted (c_sorted[g]),
            .i_pend   (c_pend[g]),
            .i_tag    (c_tag[g]),
            .o_valid  (c_valid[g+1]),
            .o_sorted (c_sorted[g+1]),
            .o_pend   (c_pend[g+1]),
            .o_tag    (c_tag[g+1])
        );
    end

    mf3_out_fifo #(
        .PIX_W (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (c_valid[TAPS]),
        .i_median (c_sorted[TAPS][TAPS/2]),
        .i_tag    (c_tag[TAPS]),
        .o_out    (o_out)
    );

    // Counting at acceptance keeps room in the queue for every result still in the cells.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if ((w_in_acc && w_emit) && !w_out_acc) begin
            r_pend <= r_pend + 1'b1;
        end else if (!(w_in_acc && w_emit) && w_out_acc) begin
            r_pend <= r_pend - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mf3_checker.sv =====
// Port-level assertions for the 3x3 median filter and the bind that attaches them.
`default_nettype none

module mf3_checker #(
    parameter int PIX_W = mf3_pkg::PIXEL_BITS_DEF
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [PIX_W-1:0]          i_out_median,
    input wire logic [mf3_pkg::COL_W-1:0] i_out_col,
    input wire logic [mf3_pkg::ROW_W-1:0] i_out_row,
    input wire logic                      i_out_frame_end
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request withdrawn before it was taken");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_median) && $stable(i_out_col)
            && $stable(i_out_row) && $stable(i_out_frame_end))
        else $error("stalled result changed");

    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_col != '0) && (i_out_row != '0))
        else $error("result reported for a border pixel");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered straight after reset");

endmodule

bind median_filter_3x3 mf3_checker #(
    .PIX_W (PIXEL_BITS)
) u_mf3_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_median    (o_out.median),
    .i_out_col       (o_out.centre_col),
    .i_out_row       (o_out.centre_row),
    .i_out_frame_end (o_out.frame_end)
);

`default_nettype wire
